FILE: rtl/cea_pkg.sv
// Shared types, constants and codes for the congestion event admission block.
// No dependencies; imported by every module under rtl/.
package cea_pkg;

  localparam int CONNECTIONS = 256;
  localparam int CONN_W      = $clog2(CONNECTIONS);
  localparam int ACKED_BITS  = 8;

  localparam logic [15:0] ACKED_LIM   = 16'((32'd1 << ACKED_BITS) - 32'd1);
  localparam logic [15:0] COUNTER_MAX = 16'hFFFF;
  localparam logic [7:0]  RETX_CLAMP_FROM = 8'd7;
  localparam logic [2:0]  RETX_CLAMP_TO   = 3'd6;

  // Item operation codes
  localparam logic [2:0] OP_ACK      = 3'd0;
  localparam logic [2:0] OP_NACK     = 3'd1;
  localparam logic [2:0] OP_TIMEOUT  = 3'd2;
  localparam logic [2:0] OP_RESPONSE = 3'd3;
  localparam logic [2:0] OP_ADD_ACK  = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_TIER_ONE   = 3'd0;
  localparam logic [2:0] CFG_TIER_TWO   = 3'd1;
  localparam logic [2:0] CFG_TIER_THREE = 3'd2;
  localparam logic [2:0] CFG_QUEUE_CAP  = 3'd3;
  localparam logic [2:0] CFG_TIME_GAP   = 3'd4;
  localparam logic [2:0] CFG_ACKED_MIN  = 3'd5;

  typedef struct packed {
    logic [9:0]  tier_one;
    logic [9:0]  tier_two;
    logic [9:0]  tier_three;
    logic [9:0]  queue_cap;
    logic [31:0] min_gap;
    logic [15:0] acked_min;
  } cfg_t;

  // One connection table entry
  typedef struct packed {
    logic        flag;
    logic [31:0] last_time;
    logic        time_valid;
    logic [15:0] count;
  } entry_t;

  typedef struct packed {
    logic                  admitted;
    logic [ACKED_BITS-1:0] acked;
    logic [2:0]            retx;
  } res_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

FILE: rtl/congestion_event_admission.sv
// Top level of the congestion event admission filter.
// Depends on cea_pkg, cea_cfg_regs, cea_conn_table and cea_admit_logic.
//
// Usage:
//  - Input channel (in_valid/in_ready): one transaction carries an event
//    (ack, nack, timeout, response, add-acked-count) for one connection.
//  - Output channel (out_valid/out_ready): exactly one result transaction
//    per input transaction, in order.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): ready
//    whenever reset is low; write only while the block is idle.
// Timing: the input transaction launches the table read; in the execute state the
// read data is checked, and the entry is written back and the result registered once
// the output register is free. in_ready is high in idle only, so the next item
// is accepted in the cycle after the result is registered, even while that
// result still waits downstream.
// Stall: if the previous result has not been taken, the item holds in the
// execute step with its read data until the output register frees up.
// Reset: config registers clear, entry valid bits clear so every connection
// reads as all zero state; no clearing pass, ready the cycle after reset.
module congestion_event_admission import cea_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            op,
  input  logic [7:0]            conn_id,
  input  logic [31:0]           now_time,
  input  logic [9:0]            queue_level,
  input  logic [7:0]            acked_add,
  input  logic [7:0]            retx_count_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  admitted,
  output logic [2:0]            event_kind,
  output logic [7:0]            conn_out,
  output logic [ACKED_BITS-1:0] acked_out,
  output logic [2:0]            retx_count_out,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  state_t      state, state_next;
  cfg_t        cfg;
  entry_t      rd_entry;
  entry_t      wr_entry;
  logic        lg_wr_en;
  res_t        res;
  logic        in_fire;
  logic        done;

  // latched item
  logic [2:0]  op_q;
  logic [7:0]  conn_q;
  logic [31:0] now_q;
  logic [9:0]  level_q;
  logic [7:0]  add_q;
  logic [7:0]  retx_q;

  // nothing is taken while reset is held
  assign cfg_ready = !rst;
  assign in_ready  = (state == ST_IDLE) && !rst;
  assign in_fire   = in_valid && in_ready;
  // execute completes once the output register is free
  assign done      = (state == ST_EXEC) && (!out_valid || out_ready);

  cea_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  cea_conn_table u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (in_fire),
    .rd_addr  (conn_id[CONN_W-1:0]),
    .rd_entry (rd_entry),
    .wr_en    (done && lg_wr_en),
    .wr_addr  (conn_q[CONN_W-1:0]),
    .wr_entry (wr_entry)
  );

  cea_admit_logic u_logic (
    .cfg           (cfg),
    .entry         (rd_entry),
    .op            (op_q),
    .conn_id       (conn_q),
    .now_time      (now_q),
    .queue_level   (level_q),
    .acked_add     (add_q),
    .retx_count_in (retx_q),
    .wr_en         (lg_wr_en),
    .wr_entry      (wr_entry),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_fire) state_next = ST_EXEC;
      ST_EXEC: if (done)    state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // item capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q    <= op;
      conn_q  <= conn_id;
      now_q   <= now_time;
      level_q <= queue_level;
      add_q   <= acked_add;
      retx_q  <= retx_count_in;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      admitted       <= res.admitted;
      event_kind     <= op_q;
      conn_out       <= conn_q;
      acked_out      <= res.acked;
      retx_count_out <= res.retx;
    end
  end

endmodule

FILE: rtl/cea_cfg_regs.sv
// Configuration register file for the admission thresholds and predicates.
// Depends on cea_pkg.
module cea_cfg_regs import cea_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_TIER_ONE:   cfg.tier_one   <= wr_data[9:0];
        CFG_TIER_TWO:   cfg.tier_two   <= wr_data[9:0];
        CFG_TIER_THREE: cfg.tier_three <= wr_data[9:0];
        CFG_QUEUE_CAP:  cfg.queue_cap  <= wr_data[9:0];
        CFG_TIME_GAP:   cfg.min_gap    <= wr_data;
        CFG_ACKED_MIN:  cfg.acked_min  <= wr_data[15:0];
        default: ;  // unused index, dropped
      endcase
    end
  end

endmodule

FILE: rtl/cea_conn_table.sv
// Per-connection state memory with registered read.
// Entry valid bits make never-written entries read as zero. Depends on cea_pkg.
module cea_conn_table import cea_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [CONN_W-1:0] rd_addr,
  output entry_t            rd_entry,
  input  logic              wr_en,
  input  logic [CONN_W-1:0] wr_addr,
  input  entry_t            wr_entry
);

  entry_t             mem [CONNECTIONS];
  logic [CONNECTIONS-1:0] vld;
  entry_t             rd_data;
  logic               rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_entry = rd_vld ? rd_data : '0;

endmodule

FILE: rtl/cea_admit_logic.sv
// Admission decision and entry update for one item.
// Pure combinational; depends on cea_pkg.
module cea_admit_logic import cea_pkg::*; (
  input  cfg_t        cfg,
  input  entry_t      entry,
  input  logic [2:0]  op,
  input  logic [7:0]  conn_id,
  input  logic [31:0] now_time,
  input  logic [9:0]  queue_level,
  input  logic [7:0]  acked_add,
  input  logic [7:0]  retx_count_in,
  output logic        wr_en,
  output entry_t      wr_entry,
  output res_t        res
);

  logic        in_range;
  logic [31:0] gap;
  logic [15:0] cnt_eff;
  logic        tp;
  logic        cp;
  logic        tier_ok;
  logic        may;
  logic [16:0] sum;

  assign in_range = 32'(conn_id) < CONNECTIONS;
  assign gap      = now_time - entry.last_time;
  // timeout clears the counter before the decision
  assign cnt_eff  = (op == OP_TIMEOUT) ? 16'd0 : entry.count;
  assign tp       = !entry.time_valid || (gap >= cfg.min_gap);
  assign cp       = cnt_eff >= cfg.acked_min;
  assign sum      = {1'b0, entry.count} + {9'd0, acked_add};

  always_comb begin
    if (queue_level < cfg.tier_one) begin
      tier_ok = 1'b1;
    end else if (queue_level < cfg.tier_two) begin
      tier_ok = tp || cp;
    end else if (queue_level < cfg.tier_three) begin
      tier_ok = tp;
    end else if (queue_level < cfg.queue_cap) begin
      tier_ok = tp && cp;
    end else begin
      tier_ok = 1'b0;
    end
  end

  assign may = !entry.flag && tier_ok;

  always_comb begin
    wr_en    = 1'b0;
    wr_entry = entry;
    res      = '0;
    if (in_range) begin
      unique case (op) inside
        OP_ACK, OP_NACK: begin
          if (may) begin
            wr_en        = 1'b1;
            wr_entry     = '{flag: 1'b1, last_time: now_time, time_valid: 1'b1,
                             count: 16'd0};
            res.admitted = 1'b1;
            res.acked    = (entry.count > ACKED_LIM) ? ACKED_LIM[ACKED_BITS-1:0]
                                                     : entry.count[ACKED_BITS-1:0];
          end
        end
        OP_TIMEOUT: begin
          wr_en          = 1'b1;
          wr_entry.count = 16'd0;
          res.retx       = (retx_count_in >= RETX_CLAMP_FROM) ? RETX_CLAMP_TO
                                                             : retx_count_in[2:0];
          if (may) begin
            wr_entry.flag       = 1'b1;
            wr_entry.last_time  = now_time;
            wr_entry.time_valid = 1'b1;
            res.admitted        = 1'b1;
          end
        end
        OP_RESPONSE: begin
          if (entry.flag) begin
            wr_en         = 1'b1;
            wr_entry.flag = 1'b0;
            res.admitted  = 1'b1;
          end
        end
        OP_ADD_ACK: begin
          wr_en          = 1'b1;
          wr_entry.count = sum[16] ? COUNTER_MAX : sum[15:0];
        end
        default: ;  // unknown op: no change
      endcase
    end
  end

endmodule
